### hw/rtl/fsrq_pkg.sv
`default_nettype none

package fsrq_pkg;

    localparam int TASK_DEPTH  = 64;
    localparam int QUEUE_DEPTH = 32;
    localparam int TASK_AW     = $clog2(TASK_DEPTH);
    localparam int SLOT_AW     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 6;
    localparam int LVL_W       = 6;
    localparam int VT_W        = 64;
    localparam int WT_W        = 17;
    localparam int WSUM_W      = 22;
    localparam int LEVELS      = 40;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);
    localparam int DIV_CW      = $clog2(VT_W);
    localparam int HALF_W      = VT_W / 2;
    localparam int PP_W        = HALF_W + WT_W;
    localparam logic [LVL_W-1:0] NICE0_RESET = LVL_W'(20);
    localparam logic [LVL_W-1:0] LEVEL_MAX   = LVL_W'(LEVELS - 1);

    localparam logic [WT_W-1:0] WEIGHT_TABLE [LEVELS] = '{
        17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291,
        17'd29154, 17'd23254, 17'd18705, 17'd14949, 17'd11916,
        17'd9548,  17'd7620,  17'd6100,  17'd4904,  17'd3906,
        17'd3121,  17'd2501,  17'd1991,  17'd1586,  17'd1277,
        17'd1024,  17'd820,   17'd655,   17'd526,   17'd423,
        17'd335,   17'd272,   17'd215,   17'd172,   17'd137,
        17'd110,   17'd87,    17'd70,    17'd56,    17'd45,
        17'd36,    17'd29,    17'd23,    17'd18,    17'd15
    };

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_ENQ   = 2'd2,
        ACT_SCHED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOCUR = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_LOAD,
        BK_T_RD,
        BK_T_LD,
        BK_T_DV,
        BK_T_RS,
        BK_I_KEY,
        BK_I_CAP,
        BK_I_WALK,
        BK_I_WS,
        BK_I_WC,
        BK_I_SRD,
        BK_I_SWR,
        BK_I_PUT,
        BK_P_RD,
        BK_P_HD,
        BK_P_LV,
        BK_P_SRD,
        BK_P_SWR,
        BK_O_RD,
        BK_O_CAP
    } back_state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_LO,
        MD_HI,
        MD_ADD,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [ID_W-1:0]  task_id;
        logic [LVL_W-1:0] prio_index;
        logic [VT_W-1:0]  start_run_time;
        logic             requeue_current;
    } in_word_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_task;
        logic [VT_W-1:0]   out_vruntime;
        logic [5:0]        queued_count;
        logic [WSUM_W-1:0] weight_sum;
        logic [1:0]        status;
    } out_word_t;

    typedef struct packed {
        action_t            act;
        logic [TASK_AW-1:0] id;
        logic [LVL_W-1:0]   lvl;
        logic [VT_W-1:0]    start;
        logic               rq;
    } cmd_t;

    function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lvl);
        return (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    endfunction

    function automatic logic [WT_W-1:0] weight_of(input logic [LVL_W-1:0] lvl);
        logic [LVL_W-1:0] c;
        c = clamp_level(lvl);
        return WEIGHT_TABLE[c];
    endfunction

    function automatic logic wrap_less(input logic [VT_W-1:0] a, input logic [VT_W-1:0] b);
        logic [VT_W-1:0] d;
        d = a - b;
        return d[VT_W-1];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fair_share_run_queue.sv
`default_nettype none

// Weighted fair-share run queue for one processor.
// Input channel in_valid/in_ready/in_data carries one command word: load a
// task entry, tick the current task, enqueue a task, or schedule the next.
// Every command returns exactly one result word on out_valid/out_ready/out_data.
// cfg_we/cfg_wdata write the reference priority level; write only when idle.
// A front stage registers and decodes commands into a two-entry queue; the
// back sequencer runs one command at a time against the task table, the
// sorted queue memory and a shared multiply/divide unit.
// A tick whose virtual run time is raised to the floor makes two passes of the
// 64-step divider; an enqueue walks the queued tasks up to the insertion point
// and shifts those behind it; schedule adds a pop that shifts every remaining
// queued task.
// Reset clears the queue, weight sum, floor and current task; task entries
// hold nothing until loaded. A stalled receiver holds the result word in the
// output register; up to four further commands are taken meanwhile.
module fair_share_run_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [fsrq_pkg::LVL_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire fsrq_pkg::in_word_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output fsrq_pkg::out_word_t             out_data
);

    logic [fsrq_pkg::LVL_W-1:0] nice0_reg;
    logic                       push_valid, push_ready, cmd_valid, cmd_ready;
    fsrq_pkg::cmd_t             push_cmd, cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nice0_reg <= fsrq_pkg::NICE0_RESET;
        end
        else if (cfg_we)
        begin
            nice0_reg <= cfg_wdata;
        end
    end

    fsrq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    fsrq_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    fsrq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .nice0     (nice0_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_nocur_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == 2'(fsrq_pkg::ST_NOCUR)
        |-> out_data.out_task == '0 && out_data.out_vruntime == '0)
        else $error("tick without current task shows a task");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == 2'(fsrq_pkg::ST_EMPTY)
        |-> out_data.queued_count == '0)
        else $error("empty status with queued tasks");

    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == 2'(fsrq_pkg::ST_FULL)
        |-> out_data.queued_count == 6'(fsrq_pkg::QUEUE_DEPTH))
        else $error("full status below queue depth");

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command queue dropped a waiting word");

endmodule

`default_nettype wire

### hw/rtl/fsrq_front.sv
`default_nettype none

module fsrq_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fsrq_pkg::in_word_t in_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output fsrq_pkg::cmd_t         push_cmd
);

    logic           hold_valid_reg, hold_valid_next;
    fsrq_pkg::cmd_t hold_reg;
    fsrq_pkg::cmd_t decoded;
    logic           take;

    always_comb
    begin
        decoded.act   = fsrq_pkg::action_t'(in_data.action);
        decoded.id    = in_data.task_id[fsrq_pkg::TASK_AW-1:0];
        decoded.lvl   = fsrq_pkg::clamp_level(in_data.prio_index);
        decoded.start = in_data.start_run_time;
        decoded.rq    = in_data.requeue_current;
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= decoded;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fsrq_cmdq.sv
`default_nettype none

module fsrq_cmdq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire fsrq_pkg::cmd_t  push_cmd,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output fsrq_pkg::cmd_t       pop_cmd
);

    fsrq_pkg::cmd_t                   slot_reg [fsrq_pkg::CMDQ_DEPTH];
    logic [fsrq_pkg::CMDQ_AW-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [fsrq_pkg::CMDQ_CW-1:0]     cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign push_ready = cnt_reg != fsrq_pkg::CMDQ_CW'(fsrq_pkg::CMDQ_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_cmd    = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + fsrq_pkg::CMDQ_AW'(1) : wp_reg;
        rp_next  = do_pop ? rp_reg + fsrq_pkg::CMDQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + fsrq_pkg::CMDQ_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - fsrq_pkg::CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fsrq_muldiv.sv
`default_nettype none

// q = (a * m mod 2^64) / d; two partial products, then one quotient bit a cycle
module fsrq_muldiv (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [fsrq_pkg::VT_W-1:0]    a,
    input  wire logic [fsrq_pkg::WT_W-1:0]    m,
    input  wire logic [fsrq_pkg::WT_W-1:0]    d,
    output logic                              done,
    output logic [fsrq_pkg::VT_W-1:0]         q
);

    fsrq_pkg::md_state_t               state_reg, state_next;
    logic                              done_reg, done_next;
    logic [fsrq_pkg::DIV_CW-1:0]       cnt_reg, cnt_next;
    logic [fsrq_pkg::VT_W-1:0]         a_reg, acc_reg, acc_next;
    logic [fsrq_pkg::WT_W-1:0]         m_reg, d_reg;
    logic [fsrq_pkg::PP_W-1:0]         pp_reg, pp_next;
    logic [fsrq_pkg::WT_W-1:0]         rem_reg, rem_next;
    logic [fsrq_pkg::WT_W:0]           trial;

    assign done  = done_reg;
    assign q     = acc_reg;
    assign trial = {rem_reg, acc_reg[fsrq_pkg::VT_W-1]};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            fsrq_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    state_next = fsrq_pkg::MD_LO;
                end
            end
            fsrq_pkg::MD_LO:
            begin
                pp_next    = a_reg[fsrq_pkg::HALF_W-1:0] * m_reg;
                state_next = fsrq_pkg::MD_HI;
            end
            fsrq_pkg::MD_HI:
            begin
                acc_next   = fsrq_pkg::VT_W'(pp_reg);
                pp_next    = a_reg[fsrq_pkg::VT_W-1:fsrq_pkg::HALF_W] * m_reg;
                state_next = fsrq_pkg::MD_ADD;
            end
            fsrq_pkg::MD_ADD:
            begin
                acc_next   = acc_reg + {pp_reg[fsrq_pkg::HALF_W-1:0],
                                        {fsrq_pkg::HALF_W{1'b0}}};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = fsrq_pkg::MD_DIV;
            end
            fsrq_pkg::MD_DIV:
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    rem_next = fsrq_pkg::WT_W'(trial - {1'b0, d_reg});
                    acc_next = {acc_reg[fsrq_pkg::VT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[fsrq_pkg::WT_W-1:0];
                    acc_next = {acc_reg[fsrq_pkg::VT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + fsrq_pkg::DIV_CW'(1);
                if (cnt_reg == fsrq_pkg::DIV_CW'(fsrq_pkg::VT_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = fsrq_pkg::MD_IDLE;
                end
            end
            default:
            begin
                state_next = fsrq_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsrq_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        rem_reg <= rem_next;
        if (state_reg == fsrq_pkg::MD_IDLE && start)
        begin
            a_reg <= a;
            m_reg <= m;
            d_reg <= d;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fsrq_back.sv
`default_nettype none

module fsrq_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire fsrq_pkg::cmd_t             cmd,
    input  wire logic [fsrq_pkg::LVL_W-1:0] nice0,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output fsrq_pkg::out_word_t             out_data
);

    localparam int TA = fsrq_pkg::TASK_AW;
    localparam int SA = fsrq_pkg::SLOT_AW;
    localparam int CW = fsrq_pkg::CNT_W;
    localparam int VW = fsrq_pkg::VT_W;
    localparam int WW = fsrq_pkg::WT_W;
    localparam int SW = fsrq_pkg::WSUM_W;
    localparam int LW = fsrq_pkg::LVL_W;

    // task table and sorted queue
    logic [LW-1:0] lvl_mem  [fsrq_pkg::TASK_DEPTH];
    logic [VW-1:0] rt_mem   [fsrq_pkg::TASK_DEPTH];
    logic [VW-1:0] vr_mem   [fsrq_pkg::TASK_DEPTH];
    logic [TA-1:0] slot_mem [fsrq_pkg::QUEUE_DEPTH];

    logic [LW-1:0] lvl_rd;
    logic [VW-1:0] rt_rd, vr_rd;
    logic [TA-1:0] slot_rd;

    logic [TA-1:0] tadr;
    logic [SA-1:0] slot_ra, slot_wa;
    logic [TA-1:0] slot_wd;
    logic          slot_we, lvl_we, rt_we, vr_we;
    logic [TA-1:0] t_wa;
    logic [LW-1:0] lvl_wd;
    logic [VW-1:0] rt_wd, vr_wd;

    fsrq_pkg::back_state_t state_reg, state_next;
    fsrq_pkg::action_t     act_reg, act_next;
    fsrq_pkg::status_t     status_reg, status_next;
    logic [TA-1:0] id_reg, id_next, tgt_reg, tgt_next, run_reg, run_next, head_reg, head_next;
    logic          runv_reg, runv_next;
    logic [LW-1:0] lvlin_reg, lvlin_next;
    logic [VW-1:0] start_reg, start_next, key_reg, key_next, rt_reg, rt_next;
    logic [VW-1:0] floor_reg, floor_next;
    logic [WW-1:0] win_reg, win_next;
    logic [CW-1:0] pos_reg, pos_next, idx_reg, idx_next, fill_reg, fill_next, idx_m1;
    logic [SW-1:0] wsum_reg, wsum_next;
    logic          out_valid_reg, out_valid_next;
    fsrq_pkg::out_word_t out_reg, out_next;

    logic          md_start, md_done;
    logic [VW-1:0] md_a, md_q;
    logic [WW-1:0] md_m, md_d, w0;
    logic [TA-1:0] shown;
    logic          showv, full;

    assign w0        = fsrq_pkg::weight_of(nice0);
    assign full      = fill_reg >= CW'(fsrq_pkg::QUEUE_DEPTH);
    assign idx_m1    = idx_reg - CW'(1);
    assign shown     = (act_reg == fsrq_pkg::ACT_SCHED || act_reg == fsrq_pkg::ACT_TICK)
                       ? run_reg : id_reg;
    assign showv     = (act_reg == fsrq_pkg::ACT_SCHED || act_reg == fsrq_pkg::ACT_TICK)
                       ? runv_reg : 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    fsrq_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .m     (md_m),
        .d     (md_d),
        .done  (md_done),
        .q     (md_q)
    );

    always_comb
    begin
        logic [VW-1:0] raised;
        raised         = fsrq_pkg::wrap_less(md_q, floor_reg) ? floor_reg : md_q;
        state_next     = state_reg;
        act_next       = act_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        tgt_next       = tgt_reg;
        run_next       = run_reg;
        runv_next      = runv_reg;
        head_next      = head_reg;
        lvlin_next     = lvlin_reg;
        start_next     = start_reg;
        key_next       = key_reg;
        rt_next        = rt_reg;
        floor_next     = floor_reg;
        win_next       = win_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        wsum_next      = wsum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        tadr           = id_reg;
        slot_ra        = '0;
        slot_we        = 1'b0;
        slot_wa        = '0;
        slot_wd        = tgt_reg;
        lvl_we         = 1'b0;
        rt_we          = 1'b0;
        vr_we          = 1'b0;
        t_wa           = run_reg;
        lvl_wd         = lvlin_reg;
        rt_wd          = rt_reg;
        vr_wd          = raised;
        md_start       = 1'b0;
        md_a           = rt_reg;
        md_m           = w0;
        md_d           = win_reg;

        unique case (state_reg)
            fsrq_pkg::BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    act_next    = cmd.act;
                    id_next     = cmd.id;
                    lvlin_next  = cmd.lvl;
                    start_next  = cmd.start;
                    status_next = fsrq_pkg::ST_OK;
                    unique case (cmd.act)
                        fsrq_pkg::ACT_LOAD:
                        begin
                            state_next = fsrq_pkg::BK_LOAD;
                        end
                        fsrq_pkg::ACT_TICK:
                        begin
                            if (runv_reg)
                            begin
                                state_next = fsrq_pkg::BK_T_RD;
                            end
                            else
                            begin
                                status_next = fsrq_pkg::ST_NOCUR;
                                state_next  = fsrq_pkg::BK_O_RD;
                            end
                        end
                        fsrq_pkg::ACT_ENQ:
                        begin
                            if (full)
                            begin
                                status_next = fsrq_pkg::ST_FULL;
                                state_next  = fsrq_pkg::BK_O_RD;
                            end
                            else
                            begin
                                tgt_next   = cmd.id;
                                state_next = fsrq_pkg::BK_I_KEY;
                            end
                        end
                        fsrq_pkg::ACT_SCHED:
                        begin
                            if (cmd.rq && runv_reg)
                            begin
                                if (full)
                                begin
                                    status_next = fsrq_pkg::ST_FULL;
                                    state_next  = fsrq_pkg::BK_O_RD;
                                end
                                else
                                begin
                                    tgt_next   = run_reg;
                                    state_next = fsrq_pkg::BK_I_KEY;
                                end
                            end
                            else
                            begin
                                state_next = fsrq_pkg::BK_P_RD;
                            end
                        end
                        default:
                        begin
                            state_next = fsrq_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            fsrq_pkg::BK_LOAD:
            begin
                t_wa       = id_reg;
                lvl_we     = 1'b1;
                rt_we      = 1'b1;
                vr_we      = 1'b1;
                rt_wd      = start_reg;
                vr_wd      = start_reg;
                state_next = fsrq_pkg::BK_O_RD;
            end
            fsrq_pkg::BK_T_RD:
            begin
                tadr       = run_reg;
                state_next = fsrq_pkg::BK_T_LD;
            end
            fsrq_pkg::BK_T_LD:
            begin
                tadr       = run_reg;
                win_next   = fsrq_pkg::weight_of(lvl_rd);
                rt_next    = rt_rd + VW'(1);
                md_start   = 1'b1;
                md_a       = rt_rd + VW'(1);
                md_m       = w0;
                md_d       = fsrq_pkg::weight_of(lvl_rd);
                state_next = fsrq_pkg::BK_T_DV;
            end
            fsrq_pkg::BK_T_DV:
            begin
                if (md_done)
                begin
                    vr_we      = 1'b1;
                    floor_next = fsrq_pkg::wrap_less(floor_reg, raised) ? raised : floor_reg;
                    if (raised != md_q)
                    begin
                        // raised to the floor: derive run time back from it
                        md_start   = 1'b1;
                        md_a       = raised;
                        md_m       = win_reg;
                        md_d       = w0;
                        state_next = fsrq_pkg::BK_T_RS;
                    end
                    else
                    begin
                        rt_we      = 1'b1;
                        state_next = fsrq_pkg::BK_O_RD;
                    end
                end
            end
            fsrq_pkg::BK_T_RS:
            begin
                if (md_done)
                begin
                    rt_we      = 1'b1;
                    rt_wd      = md_q;
                    state_next = fsrq_pkg::BK_O_RD;
                end
            end
            fsrq_pkg::BK_I_KEY:
            begin
                tadr       = tgt_reg;
                state_next = fsrq_pkg::BK_I_CAP;
            end
            fsrq_pkg::BK_I_CAP:
            begin
                key_next   = vr_rd;
                win_next   = fsrq_pkg::weight_of(lvl_rd);
                pos_next   = '0;
                state_next = fsrq_pkg::BK_I_WALK;
            end
            fsrq_pkg::BK_I_WALK:
            begin
                if (pos_reg >= fill_reg)
                begin
                    idx_next   = fill_reg;
                    state_next = fsrq_pkg::BK_I_SRD;
                end
                else
                begin
                    slot_ra    = pos_reg[SA-1:0];
                    state_next = fsrq_pkg::BK_I_WS;
                end
            end
            fsrq_pkg::BK_I_WS:
            begin
                tadr       = slot_rd;
                state_next = fsrq_pkg::BK_I_WC;
            end
            fsrq_pkg::BK_I_WC:
            begin
                if (fsrq_pkg::wrap_less(key_reg, vr_rd))
                begin
                    idx_next   = fill_reg;
                    state_next = fsrq_pkg::BK_I_SRD;
                end
                else
                begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = fsrq_pkg::BK_I_WALK;
                end
            end
            fsrq_pkg::BK_I_SRD:
            begin
                if (idx_reg > pos_reg)
                begin
                    slot_ra    = idx_m1[SA-1:0];
                    state_next = fsrq_pkg::BK_I_SWR;
                end
                else
                begin
                    state_next = fsrq_pkg::BK_I_PUT;
                end
            end
            fsrq_pkg::BK_I_SWR:
            begin
                slot_we    = 1'b1;
                slot_wa    = idx_reg[SA-1:0];
                slot_wd    = slot_rd;
                idx_next   = idx_m1;
                state_next = fsrq_pkg::BK_I_SRD;
            end
            fsrq_pkg::BK_I_PUT:
            begin
                slot_we    = 1'b1;
                slot_wa    = pos_reg[SA-1:0];
                slot_wd    = tgt_reg;
                fill_next  = fill_reg + CW'(1);
                wsum_next  = wsum_reg + SW'(win_reg);
                state_next = (act_reg == fsrq_pkg::ACT_ENQ) ? fsrq_pkg::BK_O_RD
                                                            : fsrq_pkg::BK_P_RD;
            end
            fsrq_pkg::BK_P_RD:
            begin
                if (fill_reg == '0)
                begin
                    status_next = fsrq_pkg::ST_EMPTY;
                    state_next  = fsrq_pkg::BK_O_RD;
                end
                else
                begin
                    state_next = fsrq_pkg::BK_P_HD;
                end
            end
            fsrq_pkg::BK_P_HD:
            begin
                head_next  = slot_rd;
                tadr       = slot_rd;
                idx_next   = CW'(1);
                state_next = fsrq_pkg::BK_P_LV;
            end
            fsrq_pkg::BK_P_LV:
            begin
                wsum_next  = wsum_reg - SW'(fsrq_pkg::weight_of(lvl_rd));
                state_next = fsrq_pkg::BK_P_SRD;
            end
            fsrq_pkg::BK_P_SRD:
            begin
                if (idx_reg < fill_reg)
                begin
                    slot_ra    = idx_reg[SA-1:0];
                    state_next = fsrq_pkg::BK_P_SWR;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    run_next   = head_reg;
                    runv_next  = 1'b1;
                    state_next = fsrq_pkg::BK_O_RD;
                end
            end
            fsrq_pkg::BK_P_SWR:
            begin
                slot_we    = 1'b1;
                slot_wa    = idx_m1[SA-1:0];
                slot_wd    = slot_rd;
                idx_next   = idx_reg + CW'(1);
                state_next = fsrq_pkg::BK_P_SRD;
            end
            fsrq_pkg::BK_O_RD:
            begin
                tadr       = shown;
                state_next = fsrq_pkg::BK_O_CAP;
            end
            fsrq_pkg::BK_O_CAP:
            begin
                tadr = shown;
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_task     = showv ? fsrq_pkg::ID_W'(shown) : '0;
                    out_next.out_vruntime = showv ? vr_rd : '0;
                    out_next.queued_count = 6'(fill_reg);
                    out_next.weight_sum   = wsum_reg;
                    out_next.status       = status_reg;
                    state_next            = fsrq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = fsrq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsrq_pkg::BK_IDLE;
            fill_reg      <= '0;
            wsum_reg      <= '0;
            floor_reg     <= '0;
            run_reg       <= '0;
            runv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wsum_reg      <= wsum_next;
            floor_reg     <= floor_next;
            run_reg       <= run_next;
            runv_reg      <= runv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        tgt_reg    <= tgt_next;
        head_reg   <= head_next;
        lvlin_reg  <= lvlin_next;
        start_reg  <= start_next;
        key_reg    <= key_next;
        rt_reg     <= rt_next;
        win_reg    <= win_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[t_wa] <= lvl_wd;
        end
        if (rt_we)
        begin
            rt_mem[t_wa] <= rt_wd;
        end
        if (vr_we)
        begin
            vr_mem[t_wa] <= vr_wd;
        end
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        lvl_rd  <= lvl_mem[tadr];
        rt_rd   <= rt_mem[tadr];
        vr_rd   <= vr_mem[tadr];
        slot_rd <= slot_mem[slot_ra];
    end

endmodule

`default_nettype wire

### bench/fsrq_checker.sv
`default_nettype none

module fsrq_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [fsrq_pkg::LVL_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire fsrq_pkg::in_word_t         in_data,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire fsrq_pkg::out_word_t        out_data,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [5:0]  lvl_tab [64];
    logic [63:0] rt_tab  [64];
    logic [63:0] vr_tab  [64];
    logic [5:0]  slots   [32];
    logic [5:0]  fill;
    logic [21:0] wsum;
    logic [63:0] floor_vr;
    logic [5:0]  cur_task;
    logic        cur_valid;
    logic [5:0]  nice0;

    fsrq_pkg::out_word_t awaited[$];

    function automatic logic [63:0] level_weight(input logic [5:0] l);
        return 64'(fsrq_pkg::WEIGHT_TABLE[(l > 6'd39) ? 6'd39 : l]);
    endfunction

    function automatic logic behind(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return d[63];
    endfunction

    task automatic insert_sorted(input logic [5:0] t);
        int pos;
        pos = 0;
        while (pos < fill && !behind(vr_tab[t], vr_tab[slots[pos]]))
            pos++;
        for (int i = fill; i > pos; i--)
            slots[i] = slots[i-1];
        slots[pos] = t;
        fill = fill + 1;
        wsum = wsum + 22'(level_weight(lvl_tab[t]));
    endtask

    task automatic run_word(input fsrq_pkg::in_word_t w, output fsrq_pkg::out_word_t r);
        logic [5:0]        shown;
        logic              show;
        fsrq_pkg::status_t st;
        logic [63:0]       w0, wt, v, raised;
        logic              blocked;
        logic [5:0]        head;
        shown = w.task_id;
        show = 1'b1;
        st = fsrq_pkg::ST_OK;
        blocked = 1'b0;
        case (fsrq_pkg::action_t'(w.action))
            fsrq_pkg::ACT_LOAD:
            begin
                lvl_tab[w.task_id] = (w.prio_index > 6'd39) ? 6'd39 : w.prio_index;
                rt_tab[w.task_id] = w.start_run_time;
                vr_tab[w.task_id] = w.start_run_time;
            end
            fsrq_pkg::ACT_TICK:
            begin
                if (!cur_valid)
                begin
                    st = fsrq_pkg::ST_NOCUR;
                    show = 1'b0;
                end
                else
                begin
                    w0 = level_weight(nice0);
                    wt = level_weight(lvl_tab[cur_task]);
                    rt_tab[cur_task] = rt_tab[cur_task] + 64'd1;
                    v = (rt_tab[cur_task] * w0) / wt;
                    raised = behind(v, floor_vr) ? floor_vr : v;
                    vr_tab[cur_task] = raised;
                    if (raised != v)
                        rt_tab[cur_task] = (raised * wt) / w0;
                    if (behind(floor_vr, raised))
                        floor_vr = raised;
                    shown = cur_task;
                end
            end
            fsrq_pkg::ACT_ENQ:
            begin
                if (fill >= 32)
                    st = fsrq_pkg::ST_FULL;
                else
                    insert_sorted(w.task_id);
            end
            default:
            begin
                if (w.requeue_current && cur_valid)
                begin
                    if (fill >= 32)
                    begin
                        st = fsrq_pkg::ST_FULL;
                        blocked = 1'b1;
                    end
                    else
                        insert_sorted(cur_task);
                end
                if (!blocked)
                begin
                    if (fill == 0)
                        st = fsrq_pkg::ST_EMPTY;
                    else
                    begin
                        head = slots[0];
                        for (int i = 1; i < fill; i++)
                            slots[i-1] = slots[i];
                        fill = fill - 1;
                        wsum = wsum - 22'(level_weight(lvl_tab[head]));
                        cur_task = head;
                        cur_valid = 1'b1;
                    end
                end
                shown = cur_task;
                show = cur_valid;
            end
        endcase
        r.out_task = show ? shown : 6'd0;
        r.out_vruntime = show ? vr_tab[shown] : 64'd0;
        r.queued_count = fill;
        r.weight_sum = wsum;
        r.status = st;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fsrq_pkg::out_word_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 64; i++)
            begin
                lvl_tab[i] = '0;
                rt_tab[i] = '0;
                vr_tab[i] = '0;
            end
            for (int i = 0; i < 32; i++)
                slots[i] = '0;
            fill = '0;
            wsum = '0;
            floor_vr = '0;
            cur_task = '0;
            cur_valid = 1'b0;
            nice0 = fsrq_pkg::NICE0_RESET;
            awaited.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", out_data);
                end
                else
                begin
                    e = awaited.pop_front();
                    checked++;
                    if (e.out_task !== out_data.out_task
                        || e.out_vruntime !== out_data.out_vruntime
                        || e.queued_count !== out_data.queued_count
                        || e.weight_sum !== out_data.weight_sum
                        || e.status !== out_data.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp task %0d vr %h cnt %0d wsum %0d st %0d,",
                                      " got task %0d vr %h cnt %0d wsum %0d st %0d"},
                                     e.out_task, e.out_vruntime, e.queued_count,
                                     e.weight_sum, e.status,
                                     out_data.out_task, out_data.out_vruntime,
                                     out_data.queued_count, out_data.weight_sum,
                                     out_data.status);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                run_word(in_data, e);
                awaited.push_back(e);
            end
            if (cfg_we)
                nice0 = cfg_wdata;
            pending = awaited.size();
        end
    end
endmodule

`default_nettype wire

### bench/fair_share_run_queue_tb.sv
`default_nettype none

module fair_share_run_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [5:0]           cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    fsrq_pkg::in_word_t   in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    fsrq_pkg::out_word_t  out_data;

    int  fail_count, pending, checked;
    int  in_count = 0;
    int  sent = 0;
    int  settings = 0;
    bit  calm = 1'b0;
    int  loaded_ids[$];
    bit  loaded[64];

    fair_share_run_queue uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    fsrq_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        if (in_valid && in_ready)
            in_count <= in_count + 1;

    always @(negedge clk)
        out_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 36);

    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(0, 1000));
            1: return {$urandom, $urandom};
            2: return {32'hFFFF_FFFF, $urandom};
            3: return {32'h7FFF_FFFF, $urandom};
            default: return {8'h0, 24'($urandom), $urandom};
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input fsrq_pkg::action_t a, input logic [5:0] id,
                             input logic [5:0] lvl, input logic [63:0] st,
                             input logic rq);
        int target;
        if (!calm && $urandom_range(0, 99) < 36)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_data = '{action: a, task_id: id, prio_index: lvl,
                    start_run_time: st, requeue_current: rq};
        in_valid = 1'b1;
        target = in_count + 1;
        do @(negedge clk); while (in_count != target);
        if (a == fsrq_pkg::ACT_LOAD && !loaded[id])
        begin
            loaded[id] = 1'b1;
            loaded_ids.push_back(id);
        end
        sent++;
    endtask

    task automatic drain_and_set(input logic [5:0] v);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        settings++;
    endtask

    task automatic random_phase(input int n, input bit fill_bias);
        int r;
        logic [5:0] id;
        fsrq_pkg::action_t a;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (fill_bias)
                a = (r < 15) ? fsrq_pkg::ACT_LOAD : (r < 35) ? fsrq_pkg::ACT_TICK
                  : (r < 85) ? fsrq_pkg::ACT_ENQ : fsrq_pkg::ACT_SCHED;
            else
                a = (r < 20) ? fsrq_pkg::ACT_LOAD : (r < 50) ? fsrq_pkg::ACT_TICK
                  : (r < 65) ? fsrq_pkg::ACT_ENQ : fsrq_pkg::ACT_SCHED;
            if (a == fsrq_pkg::ACT_ENQ && loaded_ids.size() == 0)
                a = fsrq_pkg::ACT_LOAD;
            if (a == fsrq_pkg::ACT_ENQ)
                id = 6'(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]);
            else if (a == fsrq_pkg::ACT_LOAD)
                id = 6'($urandom_range(0, 63));
            else
                id = 6'($urandom);
            send_word(a, id,
                      ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 39)),
                      pick_time(), 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        drain_and_set(6'd20);

        // directed
        send_word(fsrq_pkg::ACT_TICK, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_SCHED, 6'd0, 6'd0, 64'd0, 1'b1);
        send_word(fsrq_pkg::ACT_LOAD, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_LOAD, 6'd63, 6'd39, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(fsrq_pkg::ACT_LOAD, 6'd5, 6'd63, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(fsrq_pkg::ACT_LOAD, 6'd42, 6'd20, 64'd100, 1'b0);
        send_word(fsrq_pkg::ACT_ENQ, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_ENQ, 6'd63, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_ENQ, 6'd5, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_ENQ, 6'd42, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_ENQ, 6'd42, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_SCHED, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_TICK, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_TICK, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_LOAD, 6'd42, 6'd0, 64'd7, 1'b0);
        send_word(fsrq_pkg::ACT_SCHED, 6'd0, 6'd0, 64'd0, 1'b1);
        send_word(fsrq_pkg::ACT_TICK, 6'd0, 6'd0, 64'd0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_word(fsrq_pkg::ACT_SCHED, 6'd0, 6'd0, 64'd0, 1'b0);
        send_word(fsrq_pkg::ACT_TICK, 6'd0, 6'd0, 64'd0, 1'b0);

        drain_and_set(6'd0);
        random_phase(300, 1'b1);
        drain_and_set(6'd39);
        random_phase(300, 1'b0);
        drain_and_set(6'd63);
        random_phase(250, 1'b1);
        calm = 1'b1;
        drain_and_set(6'($urandom_range(0, 39)));
        random_phase(300, 1'b0);
        calm = 1'b0;
        drain_and_set(6'($urandom_range(0, 39)));
        random_phase(400, 1'b1);

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        $display("sent %0d command words over %0d reference levels, %0d results checked",
                 sent, settings, checked);
        $display("load/tick/enqueue/schedule mixes with full and empty queue cases");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
hw/rtl/fsrq_pkg.sv
hw/rtl/fsrq_front.sv
hw/rtl/fsrq_cmdq.sv
hw/rtl/fsrq_muldiv.sv
hw/rtl/fsrq_back.sv
hw/rtl/fair_share_run_queue.sv
bench/fsrq_checker.sv
bench/fair_share_run_queue_tb.sv
